FILE: rtl/core/esrwr_pkg.sv
// Shared constants, types and helpers of the string-replacement recoder.
package esrwr_pkg;

    localparam int EXP_BITS   = 32;
    localparam int MAX_WINDOW = 5;
    localparam int EXP_W      = 32;
    localparam int WIN_W      = 3;
    localparam int CODE_W     = 3;
    localparam int DIGIT_W    = 5;
    localparam int POS_W      = 5;
    localparam int CNT_W      = $clog2(EXP_BITS + 1);

    localparam logic [CODE_W-1:0] CODE_ZERO = CODE_W'(0);
    localparam logic [CODE_W-1:0] CODE_ONE  = CODE_W'(1);
    localparam logic [CODE_W-1:0] LAST_PASS = CODE_W'(2);

    typedef struct packed {
        logic              load;
        logic              scan;
        logic [CODE_W-1:0] pass;
        logic              win_ok;
        logic              emit;
        logic [POS_W-1:0]  pos;
    } t_cmd;

    typedef struct packed {
        logic hit;
    } t_sts;

    // A code c stands for the digit 2^c - 1, truncated to the port width.
    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CODE_W-1:0] code);
        logic [31:0] full;
        full = (32'd1 << code) - 32'd1;
        return full[DIGIT_W-1:0];
    endfunction

endpackage

FILE: rtl/core/esrwr_ctrl.sv
// Controller: window register, pass and position counters, and the sequencing state machine.
module esrwr_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [esrwr_pkg::WIN_W-1:0]   i_cfg_window_size,
    output esrwr_pkg::t_cmd               o_cmd,
    input  esrwr_pkg::t_sts               i_sts
);
    import esrwr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CODE_W-1:0] r_pass,  n_pass;
    logic [CNT_W-1:0]  r_rem,   n_rem;
    logic [WIN_W-1:0]  r_window;
    logic [CODE_W-1:0] eff_win;
    logic [CNT_W-1:0]  step;
    logic [CNT_W-1:0]  rem_left;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    assign eff_win = (int'(r_window) > MAX_WINDOW) ? CODE_W'(MAX_WINDOW) : CODE_W'(r_window);

    assign o_cmd.load   = start && (r_state == S_IDLE);
    assign o_cmd.scan   = (r_state == S_SCAN);
    assign o_cmd.pass   = r_pass;
    assign o_cmd.win_ok = (r_rem >= CNT_W'(r_pass));
    assign o_cmd.emit   = (r_state == S_EMIT);
    assign o_cmd.pos    = POS_W'(r_rem - CNT_W'(1));

    assign step     = i_sts.hit ? CNT_W'(r_pass) : CNT_W'(1);
    assign rem_left = r_rem - step;

    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        n_rem   = r_rem;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_rem  = CNT_W'(EXP_BITS);
                    n_pass = eff_win;
                    // A window below two leaves plain binary, so go straight to output.
                    n_state = (eff_win >= LAST_PASS) ? S_SCAN : S_EMIT;
                end
            end
            S_SCAN: begin
                n_rem = rem_left;
                if (rem_left == CNT_W'(0)) begin
                    n_rem = CNT_W'(EXP_BITS);
                    if (r_pass == LAST_PASS) begin
                        n_state = S_EMIT;
                    end else begin
                        n_pass = r_pass - CODE_W'(1);
                    end
                end
            end
            S_EMIT: begin
                n_rem = r_rem - CNT_W'(1);
                if (r_rem == CNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pass   <= CODE_ZERO;
            r_rem    <= '0;
            r_window <= WIN_W'(3);
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
            r_rem   <= n_rem;
            if (i_cfg_valid && o_cfg_ready) begin
                r_window <= i_cfg_window_size;
            end
        end
    end

endmodule

FILE: rtl/core/esrwr_dpath.sv
// Datapath: rotating digit-code line, window match and replace, and the result registers.
module esrwr_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [esrwr_pkg::EXP_W-1:0]   i_exponent,
    input  esrwr_pkg::t_cmd               i_cmd,
    output esrwr_pkg::t_sts               o_sts,
    output logic                          o_valid,
    output logic [esrwr_pkg::DIGIT_W-1:0] o_digit,
    output logic [esrwr_pkg::POS_W-1:0]   o_position,
    output logic                          o_last
);
    import esrwr_pkg::*;

    logic [CODE_W-1:0] r_code [EXP_BITS];
    logic [CODE_W-1:0] n_code [EXP_BITS];
    logic [CODE_W-1:0] mod_code [EXP_BITS];
    logic [EXP_BITS-1:0] r_orig;
    logic                r_live;
    logic                live_now;
    logic                hit;
    logic                r_valid;
    logic [DIGIT_W-1:0]  r_digit;
    logic [POS_W-1:0]    r_pos;
    logic                r_last;

    // The digit under the scan point sits at the top of the line; the window
    // reaches down from there. A run of ones is replaced before the rotation.
    always_comb begin
        hit = i_cmd.win_ok;
        for (int l = 0; l < MAX_WINDOW; l++) begin
            if ((l < int'(i_cmd.pass)) && (r_code[EXP_BITS-1-l] != CODE_ONE)) begin
                hit = 1'b0;
            end
        end
    end

    assign o_sts.hit = hit;

    always_comb begin
        for (int p = 0; p < EXP_BITS; p++) begin
            mod_code[p] = r_code[p];
        end
        if (hit) begin
            for (int l = 0; l < MAX_WINDOW; l++) begin
                if (l + 1 < int'(i_cmd.pass)) begin
                    mod_code[EXP_BITS-1-l] = CODE_ZERO;
                end else if (l + 1 == int'(i_cmd.pass)) begin
                    mod_code[EXP_BITS-1-l] = i_cmd.pass;
                end
            end
        end
    end

    // Rotate left by the window length on a replacement, else by one.
    always_comb begin
        for (int p = 0; p < EXP_BITS; p++) begin
            n_code[p] = r_code[p];
        end
        if (i_cmd.load) begin
            for (int p = 0; p < EXP_BITS; p++) begin
                n_code[p] = i_exponent[p] ? CODE_ONE : CODE_ZERO;
            end
        end else if (i_cmd.scan) begin
            for (int p = 0; p < EXP_BITS; p++) begin
                n_code[p] = mod_code[(p + EXP_BITS - 1) % EXP_BITS];
                for (int s = 2; s <= MAX_WINDOW; s++) begin
                    if (hit && (int'(i_cmd.pass) == s)) begin
                        n_code[p] = mod_code[(p + EXP_BITS - s) % EXP_BITS];
                    end
                end
            end
        end else if (i_cmd.emit) begin
            for (int p = 0; p < EXP_BITS; p++) begin
                n_code[p] = r_code[(p + EXP_BITS - 1) % EXP_BITS];
            end
        end
    end

    // Leading positions above the exponent's top set bit produce no beat.
    assign live_now = r_live || r_orig[EXP_BITS-1];

    always_ff @(posedge i_clk) begin
        for (int p = 0; p < EXP_BITS; p++) begin
            r_code[p] <= n_code[p];
        end
        if (i_cmd.load) begin
            r_orig <= i_exponent[EXP_BITS-1:0];
        end else if (i_cmd.emit) begin
            r_orig <= {r_orig[EXP_BITS-2:0], 1'b0};
        end
        r_digit <= digit_of(r_code[EXP_BITS-1]);
        r_pos   <= i_cmd.pos;
        r_last  <= (i_cmd.pos == POS_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_live <= 1'b0;
            end else if (i_cmd.emit) begin
                r_live <= live_now;
            end
            r_valid <= i_cmd.emit && live_now;
        end
    end

    assign o_valid    = r_valid;
    assign o_digit    = r_digit;
    assign o_position = r_pos;
    assign o_last     = r_last;

endmodule

FILE: rtl/core/exponent_sr_window_recoder_core.sv
// Top level of the k-ary string-replacement exponent recoder.
//
// An exponent is taken on a cycle where start is high and busy is low. The
// block then runs one replacement pass per window length, from the window
// register's value (capped at five) down to two; each pass rotates the
// 32-entry digit-code line through the window matcher and covers 32 digit
// positions, one a cycle, or a whole window at once where a run of ones
// fills it and is replaced. An output sweep over the 32 positions follows.
// Busy stays high through the passes and the sweep, and each position
// skipped by a replacement shortens it; with a window below two only the
// sweep runs. The next exponent is taken only once busy is low again, so a
// new exponent is never taken before the last one is through.
// Digits leave on o_digit, o_position and o_last, one beat per cycle marked
// by o_valid, from the exponent's top set bit down to position zero; the
// outputs are registered. A zero exponent gives no beats. The receiver
// cannot stall the output. The window register is written through its own
// valid/ready channel, ready while the block is idle. Reset returns the
// block to idle and the window to three.
module exponent_sr_window_recoder_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [esrwr_pkg::EXP_W-1:0]   i_exponent,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [esrwr_pkg::WIN_W-1:0]   i_cfg_window_size,
    output logic                          o_valid,
    output logic [esrwr_pkg::DIGIT_W-1:0] o_digit,
    output logic [esrwr_pkg::POS_W-1:0]   o_position,
    output logic                          o_last
);
    import esrwr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    esrwr_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_window_size (i_cfg_window_size),
        .o_cmd             (cmd),
        .i_sts             (sts)
    );

    esrwr_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_exponent (i_exponent),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_valid    (o_valid),
        .o_digit    (o_digit),
        .o_position (o_position),
        .o_last     (o_last)
    );

endmodule
